### design/slxr_pkg.sv
// shared types and constants of the start/length/xor frame receiver
`default_nettype none
package slxr_pkg;

	localparam int unsigned CfgCount   = 3;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned CfgDataW   = 8;

	localparam logic [7:0] StartCodeRst    = 8'h51;
	localparam logic [5:0] StartLimitRst   = 6'd50;
	localparam logic [5:0] MessageLimitRst = 6'd50;
	localparam logic [8:0] FrameOverhead   = 9'd2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START_CODE    = 2'd0,
		REG_START_LIMIT   = 2'd1,
		REG_MESSAGE_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_ARM  = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_LOST = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HUNT = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_BADSUM   = 3'd2,
		ST_NOSTART  = 3'd3,
		ST_MSGTIME  = 3'd4,
		ST_LINKTIME = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		status_t    frame_status;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [5:0] start_limit;
		logic [5:0] message_limit;
	} cfg_t;

endpackage
`default_nettype wire

### design/slxr_cfg.sv
// configuration registers of the frame receiver
`default_nettype none
module slxr_cfg import slxr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code    <= StartCodeRst;
			cfg_q.start_limit   <= StartLimitRst;
			cfg_q.message_limit <= MessageLimitRst;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_CODE:    cfg_q.start_code    <= cfg_data;
				REG_START_LIMIT:   cfg_q.start_limit   <= cfg_data[5:0];
				REG_MESSAGE_LIMIT: cfg_q.message_limit <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### design/slxr_core.sv
// frame state machine: hunt, length, running xor and result build
`default_nettype none
module slxr_core import slxr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire req_t req,
	input  wire cfg_t cfg,
	output logic      has_result,
	output res_t      result
);

	phase_t     phase_q, phase_d;
	logic [5:0] hunt_count_q, hunt_count_d;
	logic [5:0] body_count_q, body_count_d;
	logic [5:0] bytes_taken_q, bytes_taken_d;
	logic [8:0] frame_size_q, frame_size_d;
	logic       size_known_q, size_known_d;
	logic [7:0] running_xor_q, running_xor_d;

	logic [8:0] size_now;
	logic [6:0] taken_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			hunt_count_q  <= '0;
			body_count_q  <= '0;
			bytes_taken_q <= '0;
			frame_size_q  <= '0;
			size_known_q  <= 1'b0;
			running_xor_q <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			hunt_count_q  <= hunt_count_d;
			body_count_q  <= body_count_d;
			bytes_taken_q <= bytes_taken_d;
			frame_size_q  <= frame_size_d;
			size_known_q  <= size_known_d;
			running_xor_q <= running_xor_d;
		end
	end

	// first body byte is the length, size is known from that byte on
	assign size_now  = size_known_q ? frame_size_q : ({1'b0, req.rx_byte} + FrameOverhead);
	assign taken_sum = {1'b0, bytes_taken_q} + 7'd1;

	always_comb begin
		phase_d       = phase_q;
		hunt_count_d  = hunt_count_q;
		body_count_d  = body_count_q;
		bytes_taken_d = bytes_taken_q;
		frame_size_d  = frame_size_q;
		size_known_d  = size_known_q;
		running_xor_d = running_xor_q;
		has_result    = 1'b0;
		result        = '0;
		result.frame_status = ST_BUSY;

		unique case (req.cmd)
			CMD_ARM: begin
				phase_d       = PH_HUNT;
				hunt_count_d  = '0;
				body_count_d  = '0;
				bytes_taken_d = '0;
				frame_size_d  = '0;
				size_known_d  = 1'b0;
				running_xor_d = '0;
			end
			CMD_LOST: begin
				if (phase_q == PH_HUNT || phase_q == PH_BODY) begin
					phase_d             = PH_IDLE;
					has_result          = 1'b1;
					result.frame_status = ST_LINKTIME;
					result.last         = 1'b1;
				end
			end
			CMD_BYTE: begin
				unique case (phase_q)
					PH_HUNT: begin
						hunt_count_d = hunt_count_q + 6'd1;
						if (req.rx_byte == cfg.start_code) begin
							phase_d          = PH_BODY;
							body_count_d     = '0;
							bytes_taken_d    = 6'd1;
							running_xor_d    = req.rx_byte;
							has_result       = 1'b1;
							result.data_byte = req.rx_byte;
						end else if (hunt_count_q >= cfg.start_limit) begin
							phase_d             = PH_IDLE;
							has_result          = 1'b1;
							result.frame_status = ST_NOSTART;
							result.last         = 1'b1;
						end
					end
					PH_BODY: begin
						body_count_d  = body_count_q + 6'd1;
						frame_size_d  = size_now;
						size_known_d  = 1'b1;
						bytes_taken_d = taken_sum[5:0];
						has_result    = 1'b1;
						if ({2'b00, taken_sum} >= size_now) begin
							// checksum byte equals xor of everything before it
							phase_d             = PH_IDLE;
							running_xor_d       = running_xor_q ^ req.rx_byte;
							result.frame_status = (req.rx_byte == running_xor_q) ?
								ST_OK : ST_BADSUM;
							result.data_byte    = req.rx_byte;
							result.byte_index   = bytes_taken_q;
							result.last         = 1'b1;
						end else if (body_count_q >= cfg.message_limit) begin
							phase_d             = PH_IDLE;
							result.frame_status = ST_MSGTIME;
							result.last         = 1'b1;
						end else begin
							running_xor_d     = running_xor_q ^ req.rx_byte;
							result.data_byte  = req.rx_byte;
							result.byte_index = bytes_taken_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### design/start_length_xor_frame_receiver_top.sv
// top level of the start/length/xor frame receiver
// a request transaction waits in the input stage, and its result is registered in the result stage
// throughput: one request transaction per cycle while the result side keeps up
// the rate is set by the single input stage feeding the frame logic and result register
// reset: arst_n clears both stages, the frame state (phase idle) and restores
// the configuration defaults (start code 0x51, both limits 50)
`default_nettype none
module start_length_xor_frame_receiver_top import slxr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire req_t                req,
	// result channel
	output logic                     res_valid,
	input  wire logic                res_ready,
	output res_t                     res,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	// input stage
	logic valid_s1;
	req_t req_s1;

	// result stage
	logic valid_s2;
	res_t res_s2;

	cfg_t cfg;
	logic advance;
	logic has_result;
	res_t result;

	// the stage moves on when the result slot is free or being drained,
	// so a waiting result blocks the next request transaction only while it is not being drained
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	slxr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// frame state only changes when the staged transaction is consumed
	slxr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.req        (req_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	// requests that produce nothing (arm, idle bytes, quiet hunt bytes) just drop out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_s2 <= result;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// only final results end an attempt
	a_last_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == (res.frame_status != ST_BUSY)))
		else $error("last flag disagrees with frame status");

	// failure results carry no byte
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.frame_status == ST_NOSTART || res.frame_status == ST_MSGTIME ||
			res.frame_status == ST_LINKTIME)) |-> (res.data_byte == '0 && res.byte_index == '0))
		else $error("failure result carries data");

	// an accepted transaction always lands in the input stage
	a_accept_staged: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> valid_s1)
		else $error("accepted transaction lost before the input stage");

	// a blocked input stage keeps its transaction
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("input stage dropped a stalled transaction");

endmodule
`default_nettype wire

### tb/sv/tb.sv
// testbench for the start/length/xor frame receiver: directed and random frames, self-checking
`timescale 1ns / 100ps
module tb;
	import slxr_pkg::*;

	// command code with no meaning, must be ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// generous ceiling on run length
	localparam int unsigned CYCLE_LIMIT = 400000;
	// the result register sits behind the request stage, plus margin
	localparam int unsigned SETTLE_CYCLES = 4;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	start_length_xor_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// receiver state as the testbench sees it
	// ---------------------------------------------------------------
	logic [7:0] cur_start_code;
	logic [5:0] cur_start_limit;
	logic [5:0] cur_msg_limit;

	phase_t     rx_phase;
	logic [5:0] hunt_seen;        // bytes looked at while hunting
	logic [5:0] body_seen;        // bytes past the start code
	logic [5:0] frame_pos;        // index the next frame byte will get
	logic [8:0] frame_len_total;  // length byte plus overhead
	logic       len_known;
	logic [7:0] xor_acc;

	res_t frame_results_due[$];   // results still owed by the block, oldest first

	int unsigned counted_items;   // transactions the block acts on
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned status_seen[0:7];
	bit          steady;          // when set neither side idles
	res_t        want_res;

	function automatic res_t make_res(input status_t st, input logic [7:0] b,
			input logic [5:0] idx, input logic fin);
		res_t r;
		r.frame_status = st;
		r.data_byte    = b;
		r.byte_index   = idx;
		r.last         = fin;
		return r;
	endfunction

	function automatic void clear_frame_state();
		hunt_seen       = '0;
		body_seen       = '0;
		frame_pos       = '0;
		frame_len_total = '0;
		len_known       = 1'b0;
		xor_acc         = '0;
	endfunction

	// advance the receiver by one request; returns 1 when the block acts on it
	function automatic bit next_frame_result(input req_t it, output bit has_res,
			output res_t r);
		bit         acted;
		bit         last_try;
		logic [5:0] idx;
		acted   = 1'b0;
		has_res = 1'b0;
		r       = '0;
		if (it.cmd == CMD_ARM) begin
			// arm works from any phase
			clear_frame_state();
			rx_phase = PH_HUNT;
			acted    = 1'b1;
		end else if (it.cmd == CMD_UNUSED || rx_phase == PH_IDLE) begin
			acted = 1'b0;
		end else if (it.cmd == CMD_LOST) begin
			rx_phase = PH_IDLE;
			has_res  = 1'b1;
			acted    = 1'b1;
			r        = make_res(ST_LINKTIME, 8'h00, 6'd0, 1'b1);
		end else if (rx_phase == PH_HUNT) begin
			acted     = 1'b1;
			last_try  = hunt_seen >= cur_start_limit;
			hunt_seen = hunt_seen + 6'd1;
			if (it.rx_byte == cur_start_code) begin
				rx_phase  = PH_BODY;
				body_seen = '0;
				frame_pos = 6'd1;
				xor_acc   = it.rx_byte;
				has_res   = 1'b1;
				r         = make_res(ST_BUSY, it.rx_byte, 6'd0, 1'b0);
			end else if (last_try) begin
				rx_phase = PH_IDLE;
				has_res  = 1'b1;
				r        = make_res(ST_NOSTART, 8'h00, 6'd0, 1'b1);
			end
		end else begin
			// frame body: length byte first, checksum byte last
			acted     = 1'b1;
			has_res   = 1'b1;
			last_try  = body_seen >= cur_msg_limit;
			idx       = frame_pos;
			body_seen = body_seen + 6'd1;
			if (!len_known) begin
				frame_len_total = {1'b0, it.rx_byte} + FrameOverhead;
				len_known       = 1'b1;
			end
			if (({3'b000, idx} + 9'd1) >= frame_len_total) begin
				// completion wins over the message timeout on the same byte
				r = make_res((it.rx_byte == xor_acc) ? ST_OK : ST_BADSUM,
					it.rx_byte, idx, 1'b1);
				rx_phase = PH_IDLE;
				xor_acc  = xor_acc ^ it.rx_byte;
			end else if (last_try) begin
				rx_phase = PH_IDLE;
				r        = make_res(ST_MSGTIME, 8'h00, 6'd0, 1'b1);
			end else begin
				frame_pos = idx + 6'd1;
				xor_acc   = xor_acc ^ it.rx_byte;
				r         = make_res(ST_BUSY, it.rx_byte, idx, 1'b0);
			end
		end
		return acted;
	endfunction

	// ---------------------------------------------------------------
	// result side: random stalls and the scoreboard check
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
				want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (frame_results_due.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result, status %0d byte %0d index %0d last %0d",
					$time, res.frame_status, res.data_byte, res.byte_index, res.last);
			end else begin
				want_res = frame_results_due.pop_front();
				check_field("frame_status", want_res.frame_status, res.frame_status);
				check_field("data_byte", want_res.data_byte, res.data_byte);
				check_field("byte_index", want_res.byte_index, res.byte_index);
				check_field("last", want_res.last, res.last);
				status_seen[res.frame_status]++;
			end
		end
		// stall with a chance of about 27 in a hundred unless in the steady stretch
		res_ready <= steady || ($urandom_range(0, 99) >= 27);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				frame_results_due.size());
			$display("FAIL start_length_xor_frame_receiver_top");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------
	// one request transaction; valid is left high on return so back-to-back
	// transactions need no extra assignment in the acceptance step
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
		req_t it;
		bit   has_res;
		res_t r;
		it.cmd     = cmd;
		it.rx_byte = data;
		if (!steady) begin
			while ($urandom_range(0, 99) < 27) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		// accepted at this edge, predict now
		if (next_frame_result(it, has_res, r))
			counted_items++;
		if (has_res)
			frame_results_due.push_back(r);
	endtask

	// sender pauses until every due result has come, then lets in-flight arms settle
	task automatic drain_results();
		req_valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers on back-to-back cycles while the block is idle
	task automatic apply_config(input logic [7:0] code, input logic [5:0] slim,
			input logic [5:0] mlim);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_CODE;
		cfg_data  <= code;
		@(posedge clk);
		cfg_index <= REG_START_LIMIT;
		cfg_data  <= {2'b00, slim};
		@(posedge clk);
		cfg_index <= REG_MESSAGE_LIMIT;
		cfg_data  <= {2'b00, mlim};
		@(posedge clk);
		cfg_we          <= 1'b0;
		cur_start_code  = code;
		cur_start_limit = slim;
		cur_msg_limit   = mlim;
	endtask

	// one framed response with random content, sometimes broken on purpose
	task automatic send_frame();
		int         n_noise;
		int         len;
		int         break_at;
		int         pick;
		bit         good_sum;
		logic [7:0] b;
		logic [7:0] sum;
		n_noise  = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 63) : $urandom_range(0, 3);
		pick     = $urandom_range(0, 99);
		len      = (pick < 70) ? $urandom_range(0, 6) :
			(pick < 90) ? $urandom_range(7, 24) : $urandom_range(0, 255);
		good_sum = $urandom_range(0, 99) < 75;
		break_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len) : -1;

		send_item(CMD_ARM, 8'($urandom_range(0, 255)));
		// bytes before the start code, never equal to it
		for (int i = 0; i < n_noise && rx_phase == PH_HUNT; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == cur_start_code)
				b = b ^ 8'h01;
			send_item(CMD_BYTE, b);
		end
		if (rx_phase == PH_HUNT)
			send_item(CMD_BYTE, cur_start_code);
		sum = cur_start_code;
		// length byte, body, checksum; stop once the frame attempt is over
		for (int i = 0; i <= len && rx_phase == PH_BODY; i++) begin
			if (i == 0)
				b = len[7:0];
			else if (i == len)
				b = good_sum ? sum : 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(0, 255));
			if (i == break_at) begin
				pick = $urandom_range(0, 2);
				send_item((pick == 0) ? CMD_LOST : (pick == 1) ? CMD_ARM : CMD_UNUSED,
					8'($urandom_range(0, 255)));
			end
			if (rx_phase == PH_BODY)
				send_item(CMD_BYTE, b);
			sum = sum ^ b;
		end
	endtask

	task automatic run_frames(input int budget);
		int unsigned first;
		first = counted_items;
		while (counted_items - first < budget) begin
			if ($urandom_range(0, 99) < 12) begin
				// loose commands of any kind, including ignored ones
				repeat ($urandom_range(1, 4))
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				send_frame();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// directed tests
	// ---------------------------------------------------------------
	// bytes, link loss and the unused code while idle give nothing
	task automatic test_ignored_when_idle();
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_LOST, 8'h00);
		send_item(CMD_UNUSED, 8'hA5);
	endtask

	task automatic test_link_loss();
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_LOST, 8'hFF);
	endtask

	// length zero ends on the length byte, checked against the start code
	task automatic test_short_length_bad_sum();
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_BYTE, StartCodeRst);
		send_item(CMD_BYTE, 8'h00);
	endtask

	// smallest start limit: first non-start byte ends the hunt
	task automatic test_no_start();
		apply_config(8'hFF, 6'd0, 6'd0);
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_BYTE, 8'h12);
	endtask

	// smallest message limit: the length byte itself times out and is not passed out
	task automatic test_message_timeout();
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, 8'h05);
	endtask

	// checksum lands on the last allowed byte and must still be accepted
	task automatic test_completion_on_last_byte();
		apply_config(8'hFF, 6'd0, 6'd1);
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, 8'h01);
		send_item(CMD_BYTE, 8'hFE);
	endtask

	// start code zero with length zero is a good two-byte frame
	task automatic test_zero_start_code();
		apply_config(8'h00, 6'd61, 6'd61);
		send_item(CMD_ARM, 8'h00);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'h00);
	endtask

	// ---------------------------------------------------------------
	// random tests
	// ---------------------------------------------------------------
	task automatic test_random_defaults();
		apply_config(StartCodeRst, StartLimitRst, MessageLimitRst);
		run_frames(100);
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			apply_config(8'($urandom_range(0, 255)), 6'($urandom_range(0, 10)),
				6'($urandom_range(0, 12)));
			run_frames(50);
		end
	endtask

	task automatic test_random_extremes();
		apply_config(8'h00, 6'd61, 6'd0);
		run_frames(50);
		apply_config(8'hFF, 6'd0, 6'd61);
		run_frames(50);
	endtask

	// long stretch where neither side idles
	task automatic test_random_no_idling();
		apply_config(8'($urandom_range(0, 255)), 6'd61, 6'd61);
		steady = 1'b1;
		run_frames(100);
		steady = 1'b0;
	endtask

	initial begin
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_START_CODE;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		steady          = 1'b0;
		counted_items   = 0;
		// register defaults and idle frame state, as after reset
		cur_start_code  = StartCodeRst;
		cur_start_limit = StartLimitRst;
		cur_msg_limit   = MessageLimitRst;
		rx_phase        = PH_IDLE;
		clear_frame_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_when_idle();
		test_link_loss();
		test_short_length_bad_sum();
		test_no_start();
		test_message_timeout();
		test_completion_on_last_byte();
		test_zero_start_code();
		test_random_defaults();
		test_random_settings();
		test_random_extremes();
		test_random_no_idling();

		drain_results();
		$display("run covered %0d request transactions under reset and nine register settings",
			counted_items);
		$display("results: ok %0d, bad sum %0d, no start %0d, msg time %0d, link %0d, busy %0d",
			status_seen[ST_OK], status_seen[ST_BADSUM], status_seen[ST_NOSTART],
			status_seen[ST_MSGTIME], status_seen[ST_LINKTIME], status_seen[ST_BUSY]);
		if (error_count == 0) begin
			$display("PASS start_length_xor_frame_receiver_top");
		end else begin
			$display("FAIL start_length_xor_frame_receiver_top");
		end
		$finish;
	end

endmodule

### sim.f
design/slxr_pkg.sv
design/slxr_cfg.sv
design/slxr_core.sv
design/start_length_xor_frame_receiver_top.sv
tb/sv/tb.sv
